// File: rtl/dmi_pkg.sv
// ----------------------------------------------------------------------------
// dmi_pkg: shared types and constants
// Fixed field widths, percent scaling, state encodings and the records that
// pass between the controller, the divider and the window memory.
// ----------------------------------------------------------------------------
package dmi_pkg;

	// Field widths
	localparam int PRICE_W  = 32;
	localparam int PCT_W    = 23;
	localparam int PERIOD_W = 7;

	// Percent format: Q7.16, 100.0 percent is 100 << 16
	localparam int             PCT_FRAC = 16;
	localparam logic [PCT_W-1:0] PCT_FULL = 23'd6553600;

	// Reset window length
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

	// Divider produces PCT_W quotient bits, one per step
	localparam int DIV_CNT_W = $clog2(PCT_W);

	// One window entry: true range, +DM, -DM and DX of one bar
	typedef struct packed {
		logic [PRICE_W-1:0] tr;
		logic [PRICE_W-1:0] pdm;
		logic [PRICE_W-1:0] ndm;
		logic [PCT_W-1:0]   dx;
	} ring_word_t;

	// Window memory control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ring_ctrl_t;

	// Divider request and response
	typedef struct packed {
		logic start;
		logic scale;   // 1: quotient of num * 100.0 percent, 0: plain quotient
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] quot;
	} div_rsp_t;

	// Division sequence of one bar
	typedef enum logic [1:0] {
		OP_PDI,
		OP_NDI,
		OP_DX,
		OP_ADX
	} div_op_t;

	// Divider states
	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_SCALE,
		DIV_CHECK,
		DIV_ITER,
		DIV_DONE
	} div_state_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOVE,
		ST_SUB,
		ST_ADD,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DX_PREP,
		ST_DX_ADD,
		ST_OUT
	} top_state_t;

endpackage

// File: rtl/dmi_if.sv
// ----------------------------------------------------------------------------
// dmi_if: channel interfaces
// Valid/ready channels for price bars, indicator results and the period
// register write.
// ----------------------------------------------------------------------------
interface dmi_bar_if;
	import dmi_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] high_price;
	logic [PRICE_W-1:0] low_price;
	logic [PRICE_W-1:0] close_price;

	modport source (output valid, output high_price, output low_price,
		output close_price, input ready);
	modport sink (input valid, input high_price, input low_price,
		input close_price, output ready);
endinterface

interface dmi_result_if;
	import dmi_pkg::*;

	logic             valid;
	logic             ready;
	logic [PCT_W-1:0] adx_value;
	logic [PCT_W-1:0] plus_di;
	logic [PCT_W-1:0] minus_di;

	modport source (output valid, output adx_value, output plus_di,
		output minus_di, input ready);
	modport sink (input valid, input adx_value, input plus_di,
		input minus_di, output ready);
endinterface

interface dmi_cfg_if;
	import dmi_pkg::*;

	logic                valid;
	logic                ready;
	logic [PERIOD_W-1:0] window_period;

	modport source (output valid, output window_period, input ready);
	modport sink (input valid, input window_period, output ready);
endinterface

// File: rtl/dmi_div.sv
// ----------------------------------------------------------------------------
// dmi_div: shared restoring divider
// Radix-2 restoring divider, one quotient bit per cycle. In scaled mode the
// dividend is num * 100 << 16; the quotient saturates at 100.0 percent.
// ----------------------------------------------------------------------------
module dmi_div #(
	parameter int NUM_W = 38
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dmi_pkg::div_req_t   req,
	input  logic [NUM_W-1:0]    num,
	input  logic [NUM_W-1:0]    den,
	output dmi_pkg::div_rsp_t   rsp
);
	import dmi_pkg::*;

	localparam int LOW_SCALE_W = PCT_W - PCT_FRAC;  // low bits of num * 100 below bit 23

	div_state_t             state_q, state_d;
	logic [NUM_W-1:0]       num_q, den_q, hi_q, rem_q;
	logic [PCT_W-1:0]       lo_q, quot_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   scale_q;
	logic [NUM_W+6:0]       wide, prod;
	logic [NUM_W:0]         trial, diff;
	logic                   ge;

	// num * 100 as shift-add
	assign wide = {7'b0, num_q};
	assign prod = (wide << 6) + (wide << 5) + (wide << 2);

	// one restoring step
	assign trial = {rem_q, lo_q[PCT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and response
	always_comb begin
		state_d  = state_q;
		rsp.done = 1'b0;
		rsp.quot = (quot_q > PCT_FULL) ? PCT_FULL : quot_q;
		case (state_q)
			DIV_IDLE: begin
				if (req.start) state_d = DIV_SCALE;
			end
			DIV_SCALE: state_d = DIV_CHECK;
			DIV_CHECK: begin
				state_d = (hi_q >= den_q) ? DIV_DONE : DIV_ITER;
			end
			DIV_ITER: begin
				if (cnt_q == '0) state_d = DIV_DONE;
			end
			DIV_DONE: begin
				rsp.done = 1'b1;
				state_d  = DIV_IDLE;
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				num_q   <= num;
				den_q   <= den;
				scale_q <= req.scale;
			end
			DIV_SCALE: begin
				if (scale_q) begin
					hi_q <= prod[NUM_W+6:LOW_SCALE_W];
					lo_q <= {prod[LOW_SCALE_W-1:0], {PCT_FRAC{1'b0}}};
				end else begin
					hi_q <= num_q >> PCT_W;
					lo_q <= num_q[PCT_W-1:0];
				end
			end
			DIV_CHECK: begin
				// quotient at or above 2^23 saturates at once
				quot_q <= (hi_q >= den_q) ? PCT_FULL : '0;
				rem_q  <= hi_q;
				cnt_q  <= DIV_CNT_W'(PCT_W - 1);
			end
			DIV_ITER: begin
				rem_q  <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
				quot_q <= {quot_q[PCT_W-2:0], ge};
				lo_q   <= lo_q << 1;
				cnt_q  <= cnt_q - DIV_CNT_W'(1);
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/dmi_ring.sv
// ----------------------------------------------------------------------------
// dmi_ring: window memory
// Holds TR, +DM, -DM and DX of the bars in the window; one read and one write
// per cycle, registered read data.
// ----------------------------------------------------------------------------
module dmi_ring #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  dmi_pkg::ring_ctrl_t        ctrl,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  dmi_pkg::ring_word_t        wr_data,
	output dmi_pkg::ring_word_t        rd_data
);
	import dmi_pkg::*;

	ring_word_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) mem[addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) rd_data <= mem[addr];
	end

endmodule

// File: rtl/directional_movement_index_top.sv
// ----------------------------------------------------------------------------
// directional_movement_index_top: ADX / +DI / -DI over simple moving windows
// Takes one price bar per transfer and returns ADX, +DI and -DI in Q7.16
// percent from windows of the last window_period bars.
// ----------------------------------------------------------------------------
// A bar that gives a result (any bar after the first, with a nonzero period)
// keeps the bar channel busy from its transfer until the block is idle again:
// window bookkeeping (the transfer cycle included) plus four divisions on one
// shared radix-2 divider (+DI, -DI, DX, ADX). A division whose denominator is
// zero skips the divider, and a saturating one ends after its overflow check.
// The result stage also waits for as long as the previous result has not been
// taken. A bar that gives no result only replaces the stored bar. The result
// sits in an output register, so the next bar is taken while a result waits.
// Period writes are taken only while no bar is in work; a write clears the
// stored bar and the windows. Windows are up to MAX_PERIOD bars deep and a
// larger period is clamped.
// ----------------------------------------------------------------------------
module directional_movement_index_top #(
	parameter int MAX_PERIOD = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	dmi_cfg_if.sink            cfg,
	dmi_bar_if.sink            bar,
	dmi_result_if.source       result
);
	import dmi_pkg::*;

	localparam int AW    = $clog2(MAX_PERIOD);
	localparam int PER_W = $clog2(MAX_PERIOD + 1);
	localparam int SUM_W = PRICE_W + AW;
	localparam int DXS_W = PCT_W + AW;

	top_state_t           state_q, state_d;
	div_op_t              op_q;

	logic [PERIOD_W-1:0]  period_q;
	logic [PER_W-1:0]     per;
	logic [PRICE_W-1:0]   prev_high_q, prev_low_q, prev_close_q;
	logic                 have_prev_q;
	logic [PRICE_W-1:0]   high_q, low_q, close_q;
	logic [SUM_W-1:0]     range_sum_q, plus_sum_q, minus_sum_q;
	logic [DXS_W-1:0]     dx_sum_q;
	logic [PER_W-1:0]     fill_q;
	logic [AW-1:0]        ptr_q;
	logic                 full_q;

	logic [PRICE_W-1:0]   tr_q, pdm_q, ndm_q;
	logic [PCT_W-1:0]     pdi_q, ndi_q, dx_q, adx_q;
	logic [PCT_W-1:0]     diff_q;
	logic [PCT_W:0]       disum_q;

	logic                 out_valid_q;
	logic [PCT_W-1:0]     out_adx_q, out_pdi_q, out_ndi_q;

	logic                 cfg_wr, bar_acc, out_free;
	logic [PRICE_W-1:0]   tr_top, tr_bot;
	logic signed [PRICE_W:0] pm, nm;
	logic [PER_W-1:0]     ptr_inc;

	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic                 div_start, div_scale;
	logic [SUM_W-1:0]     div_num, div_den;
	logic                 den_zero, res_take;
	logic [PCT_W-1:0]     res_val;

	ring_ctrl_t           ring_ctrl;
	ring_word_t           ring_wr, ring_rd;

	// handshakes; period writes only between bars
	assign cfg.ready     = (state_q == ST_IDLE);
	assign cfg_wr        = cfg.valid && cfg.ready;
	assign bar_acc       = bar.valid && bar.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.adx_value = out_adx_q;
	assign result.plus_di   = out_pdi_q;
	assign result.minus_di  = out_ndi_q;

	// effective window length
	assign per = (32'(period_q) > MAX_PERIOD) ? PER_W'(MAX_PERIOD) : PER_W'(period_q);

	// true range and directional moves of the held bar
	assign tr_top = (high_q > prev_close_q) ? high_q : prev_close_q;
	assign tr_bot = (low_q < prev_close_q) ? low_q : prev_close_q;
	assign pm     = $signed({1'b0, high_q}) - $signed({1'b0, prev_high_q});
	assign nm     = $signed({1'b0, prev_low_q}) - $signed({1'b0, low_q});

	// ring pointer wrap
	assign ptr_inc = PER_W'(ptr_q) + PER_W'(1);

	// divider operand select
	always_comb begin
		case (op_q)
			OP_PDI: begin
				div_num   = plus_sum_q;
				div_den   = range_sum_q;
				div_scale = 1'b1;
			end
			OP_NDI: begin
				div_num   = minus_sum_q;
				div_den   = range_sum_q;
				div_scale = 1'b1;
			end
			OP_DX: begin
				div_num   = SUM_W'(diff_q);
				div_den   = SUM_W'(disum_q);
				div_scale = 1'b1;
			end
			default: begin
				div_num   = SUM_W'(dx_sum_q);
				div_den   = SUM_W'(per);
				div_scale = 1'b0;
			end
		endcase
	end

	assign div_req  = '{start: div_start, scale: div_scale};
	assign den_zero = (div_den == '0);
	assign res_take = (state_q == ST_DIV_START && den_zero) ||
		(state_q == ST_DIV_WAIT && div_rsp.done);
	assign res_val  = (state_q == ST_DIV_WAIT) ? div_rsp.quot : '0;

	// shared divider
	dmi_div #(
		.NUM_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.rsp    (div_rsp)
	);

	// window memory
	assign ring_wr.tr  = tr_q;
	assign ring_wr.pdm = pdm_q;
	assign ring_wr.ndm = ndm_q;
	assign ring_wr.dx  = dx_q;

	dmi_ring #(
		.DEPTH (MAX_PERIOD)
	) u_ring (
		.clk     (clk),
		.ctrl    (ring_ctrl),
		.addr    (ptr_q),
		.wr_data (ring_wr),
		.rd_data (ring_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d          = state_q;
		bar.ready        = 1'b0;
		div_start        = 1'b0;
		ring_ctrl.rd_en  = 1'b0;
		ring_ctrl.wr_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// a period write goes first
				bar.ready = !cfg.valid;
				if (bar.valid && !cfg.valid && have_prev_q && per != '0)
					state_d = ST_MOVE;
			end
			ST_MOVE: begin
				ring_ctrl.rd_en = 1'b1;
				state_d         = ST_SUB;
			end
			ST_SUB: state_d = ST_ADD;
			ST_ADD: state_d = ST_DIV_START;
			ST_DIV_START,
			ST_DIV_WAIT: begin
				if (state_q == ST_DIV_START && !den_zero) begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
				if (res_take) begin
					case (op_q)
						OP_PDI:  state_d = ST_DIV_START;
						OP_NDI:  state_d = ST_DX_PREP;
						OP_DX:   state_d = ST_DX_ADD;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_DX_PREP: state_d = ST_DIV_START;
			ST_DX_ADD:  state_d = ST_DIV_START;
			ST_OUT: begin
				if (out_free) begin
					ring_ctrl.wr_en = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state: period, stored bar, window sums and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RESET;
			prev_high_q  <= '0;
			prev_low_q   <= '0;
			prev_close_q <= '0;
			have_prev_q  <= 1'b0;
			range_sum_q  <= '0;
			plus_sum_q   <= '0;
			minus_sum_q  <= '0;
			dx_sum_q     <= '0;
			fill_q       <= '0;
			ptr_q        <= '0;
			op_q         <= OP_PDI;
			out_valid_q  <= 1'b0;
		end else begin
			// output register: loaded by the result stage, emptied by a transfer
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				// period write clears all history
				period_q     <= cfg.window_period;
				prev_high_q  <= '0;
				prev_low_q   <= '0;
				prev_close_q <= '0;
				have_prev_q  <= 1'b0;
				range_sum_q  <= '0;
				plus_sum_q   <= '0;
				minus_sum_q  <= '0;
				dx_sum_q     <= '0;
				fill_q       <= '0;
				ptr_q        <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						// bar with no result only replaces the stored bar
						if (bar_acc && !(have_prev_q && per != '0)) begin
							prev_high_q  <= bar.high_price;
							prev_low_q   <= bar.low_price;
							prev_close_q <= bar.close_price;
							have_prev_q  <= 1'b1;
						end
					end
					ST_MOVE: begin
						prev_high_q  <= high_q;
						prev_low_q   <= low_q;
						prev_close_q <= close_q;
					end
					ST_SUB: begin
						// drop the oldest entry once the window is full
						if (full_q) begin
							range_sum_q <= range_sum_q - SUM_W'(ring_rd.tr);
							plus_sum_q  <= plus_sum_q - SUM_W'(ring_rd.pdm);
							minus_sum_q <= minus_sum_q - SUM_W'(ring_rd.ndm);
							dx_sum_q    <= dx_sum_q - DXS_W'(ring_rd.dx);
						end
					end
					ST_ADD: begin
						range_sum_q <= range_sum_q + SUM_W'(tr_q);
						plus_sum_q  <= plus_sum_q + SUM_W'(pdm_q);
						minus_sum_q <= minus_sum_q + SUM_W'(ndm_q);
						op_q        <= OP_PDI;
					end
					ST_DIV_START,
					ST_DIV_WAIT: begin
						if (res_take && op_q == OP_PDI) op_q <= OP_NDI;
					end
					ST_DX_PREP: op_q <= OP_DX;
					ST_DX_ADD: begin
						dx_sum_q <= dx_sum_q + DXS_W'(dx_q);
						op_q     <= OP_ADX;
					end
					ST_OUT: begin
						if (out_free) begin
							if (fill_q < per) fill_q <= fill_q + PER_W'(1);
							ptr_q <= (ptr_inc >= per) ? '0 : ptr_inc[AW-1:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (bar_acc) begin
			high_q  <= bar.high_price;
			low_q   <= bar.low_price;
			close_q <= bar.close_price;
		end
		if (state_q == ST_MOVE) begin
			tr_q   <= tr_top - tr_bot;
			pdm_q  <= (pm > nm && pm > 0) ? pm[PRICE_W-1:0] : '0;
			ndm_q  <= (nm > pm && nm > 0) ? nm[PRICE_W-1:0] : '0;
			full_q <= (fill_q >= per);
		end
		if (res_take) begin
			case (op_q)
				OP_PDI:  pdi_q <= res_val;
				OP_NDI:  ndi_q <= res_val;
				OP_DX:   dx_q  <= res_val;
				default: adx_q <= res_val;
			endcase
		end
		if (state_q == ST_DX_PREP) begin
			diff_q  <= (pdi_q > ndi_q) ? (pdi_q - ndi_q) : (ndi_q - pdi_q);
			disum_q <= {1'b0, pdi_q} + {1'b0, ndi_q};
		end
		if (state_q == ST_OUT && out_free) begin
			out_adx_q <= adx_q;
			out_pdi_q <= pdi_q;
			out_ndi_q <= ndi_q;
		end
	end

	// checks
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside of a wait state");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && per != '0) |-> (PER_W'(ptr_q) < per && fill_q <= per))
		else $error("ring pointer or fill count outside the window");

	a_out_after_adx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> op_q == OP_ADX)
		else $error("result stage reached before the ADX division");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the result stage");

endmodule

// File: tb/sv/tb_directional_movement_index_top.sv
// ----------------------------------------------------------------------------
// tb_directional_movement_index_top: ADX / +DI / -DI block regression
// Sends price bars and period writes over valid/ready channels. An in-bench
// predictor keeps its own windows and works out ADX, +DI and -DI for each
// accepted bar that yields a reading. Each returned reading is checked
// against the oldest outstanding expected reading. A short directed table
// runs first, then random phases at several window lengths, with random
// stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_directional_movement_index_top;
	import dmi_pkg::*;

	localparam int WIN_MAX        = 64;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PCT       = 27;

	typedef struct packed {
		logic [PCT_W-1:0] adx;
		logic [PCT_W-1:0] pdi;
		logic [PCT_W-1:0] ndi;
	} dmi_reading_t;

	localparam dmi_reading_t NO_MOVE = '0;

	typedef enum logic {ROW_BAR, ROW_PERIOD} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [PRICE_W-1:0]  hi;
		logic [PRICE_W-1:0]  lo;
		logic [PRICE_W-1:0]  cl;
		logic [PERIOD_W-1:0] period;
		row_check_t          check;
		dmi_reading_t        typed;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dmi_cfg_if    cfg_ch ();
	dmi_bar_if    bar_ch ();
	dmi_result_if res_ch ();

	directional_movement_index_top #(
		.MAX_PERIOD(WIN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.bar(bar_ch),
		.result(res_ch)
	);

	// Clock: period of 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] span_reg;
	logic [PRICE_W-1:0]  last_hi, last_lo, last_cl;
	bit                  seen_bar;
	logic [PRICE_W-1:0]  tr_ring [WIN_MAX];
	logic [PRICE_W-1:0]  up_ring [WIN_MAX];
	logic [PRICE_W-1:0]  dn_ring [WIN_MAX];
	logic [PCT_W-1:0]    dx_ring [WIN_MAX];
	logic [63:0]         tr_sum, up_sum, dn_sum, dx_sum;
	int unsigned         fill_cnt, slot_ptr;

	dmi_reading_t readings_due [$];
	int unsigned  mismatches = 0;

	// Receiver and watchdog bookkeeping
	bit          steady_mode = 1'b0;
	int unsigned hold_asks   = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left   = 0;
	int unsigned quiet_cycles = 0;

	// Random price walk
	longint             walk_mid = 64'd1000000;
	int                 trend    = 1;
	logic [PRICE_W-1:0] walk_close = '0;

	// A period write drops every stored bar and window entry
	function automatic void load_period(input logic [PERIOD_W-1:0] v);
		span_reg = v;
		last_hi  = '0;
		last_lo  = '0;
		last_cl  = '0;
		seen_bar = 1'b0;
		tr_sum   = '0;
		up_sum   = '0;
		dn_sum   = '0;
		dx_sum   = '0;
		fill_cnt = 0;
		slot_ptr = 0;
	endfunction

	// num / den as Q7.16 percent, truncated, clipped at 100.0
	function automatic logic [PCT_W-1:0] pct_of(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		if (den == 64'd0)
			return '0;
		q = (num * 64'(PCT_FULL)) / den;
		return (q > 64'(PCT_FULL)) ? PCT_FULL : q[PCT_W-1:0];
	endfunction

	// One bar into the windows; returns 1 when the bar yields a reading
	function automatic bit predict_bar(input logic [PRICE_W-1:0] hi, lo, cl,
			output dmi_reading_t rd);
		int unsigned        win, slot;
		bit                 had;
		logic [PRICE_W-1:0] ph, pl, pc, top, bot, tr, pdm, ndm;
		logic [PCT_W-1:0]   pdi, ndi, dxv;
		longint             pm, nm;
		rd = NO_MOVE;
		win = (span_reg > WIN_MAX) ? WIN_MAX : span_reg;
		had = seen_bar;
		ph = last_hi;
		pl = last_lo;
		pc = last_cl;
		last_hi = hi;
		last_lo = lo;
		last_cl = cl;
		seen_bar = 1'b1;
		if (!had || win == 0)
			return 1'b0;

		// True range and directional moves against the stored bar
		top = (hi > pc) ? hi : pc;
		bot = (lo < pc) ? lo : pc;
		tr  = top - bot;
		pm  = longint'(hi) - longint'(ph);
		nm  = longint'(pl) - longint'(lo);
		pdm = (pm > nm && pm > 0) ? 32'(pm) : '0;
		ndm = (nm > pm && nm > 0) ? 32'(nm) : '0;

		// Oldest entry leaves once the window is full
		slot = slot_ptr;
		if (fill_cnt >= win) begin
			tr_sum = tr_sum - 64'(tr_ring[slot]);
			up_sum = up_sum - 64'(up_ring[slot]);
			dn_sum = dn_sum - 64'(dn_ring[slot]);
			dx_sum = dx_sum - 64'(dx_ring[slot]);
		end
		tr_ring[slot] = tr;
		up_ring[slot] = pdm;
		dn_ring[slot] = ndm;
		tr_sum = tr_sum + 64'(tr);
		up_sum = up_sum + 64'(pdm);
		dn_sum = dn_sum + 64'(ndm);

		pdi = pct_of(up_sum, tr_sum);
		ndi = pct_of(dn_sum, tr_sum);
		dxv = pct_of((pdi > ndi) ? 64'(pdi - ndi) : 64'(ndi - pdi), 64'(pdi) + 64'(ndi));
		dx_ring[slot] = dxv;
		dx_sum = dx_sum + 64'(dxv);

		// Divisor is always the period, even while filling
		rd.adx = 23'(dx_sum / 64'(win));
		rd.pdi = pdi;
		rd.ndi = ndi;

		if (fill_cnt < win)
			fill_cnt++;
		slot_ptr = (slot + 1 >= win) ? 0 : slot + 1;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [PRICE_W-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Mostly a trending walk of well-formed bars, with flat bars and noise
	function automatic void next_bar(output logic [PRICE_W-1:0] hi, lo, cl);
		int unsigned pick;
		longint      jit, sp, step;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if ($urandom_range(0, 15) == 0)
				trend = -trend;
			jit  = walk_mid >>> 6;
			step = longint'(trend) * (walk_mid >>> 7)
				+ longint'($urandom_range(0, 32'(2 * jit))) - jit;
			walk_mid = walk_mid + step;
			if (walk_mid < 64'sd4096)
				walk_mid = 64'sd4096;
			if (walk_mid > 64'sd1073741824)
				walk_mid = 64'sd1073741824;
			sp = walk_mid >>> 5;
			hi = 32'(walk_mid + longint'($urandom_range(0, 32'(sp))));
			lo = 32'(walk_mid - longint'($urandom_range(0, 32'(sp))));
			cl = $urandom_range(hi, lo);
		end else if (pick < 80) begin
			hi = walk_close;
			lo = walk_close;
			cl = walk_close;
		end else if (pick < 92) begin
			hi = $urandom();
			lo = $urandom();
			cl = $urandom();
		end else begin
			hi = corner_value();
			lo = corner_value();
			cl = corner_value();
		end
		walk_close = cl;
	endfunction

	task automatic send_bar(input logic [PRICE_W-1:0] hi, lo, cl,
			input row_check_t check, input dmi_reading_t typed);
		dmi_reading_t calc;
		bit           made;
		bar_ch.valid       <= 1'b1;
		bar_ch.high_price  <= hi;
		bar_ch.low_price   <= lo;
		bar_ch.close_price <= cl;
		@(posedge clk);
		while (!bar_ch.ready)
			@(posedge clk);
		made = predict_bar(hi, lo, cl, calc);
		if (check == CHK_TYPED)
			readings_due.insert(readings_due.size(), typed);
		else if (check == CHK_MODEL && made)
			readings_due.insert(readings_due.size(), calc);
	endtask

	task automatic idle_bar(input int unsigned n);
		bar_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for every outstanding reading, then let a last no-result bar finish
	task automatic settle();
		bar_ch.valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] v);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.window_period <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		load_period(v);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [PERIOD_W-1:0] per, input int unsigned count,
			input bit steady, input bit hold);
		logic [PRICE_W-1:0] hi, lo, cl;
		settle();
		write_period(per);
		steady_mode <= steady;
		for (int unsigned i = 0; i < count; i++) begin
			if (hold && i == 8)
				hold_asks <= hold_asks + 1;
			if (!steady && $urandom_range(0, 99) < IDLE_PCT)
				idle_bar($urandom_range(1, 8));
			next_bar(hi, lo, cl);
			send_bar(hi, lo, cl, CHK_MODEL, NO_MOVE);
		end
		steady_mode <= 1'b0;
	endtask

	// Directed table: first bar, zero TR, saturated DI, zero DI sum,
	// period zero, clamped period and the price extremes
	plan_row_t plan [22] = '{
		'{ROW_BAR, 32'd0, 32'd0, 32'd0, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd0, 32'd0, 32'd0, 7'd0, CHK_TYPED, NO_MOVE},
		'{ROW_BAR, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 7'd0, CHK_MODEL, NO_MOVE},
		'{ROW_BAR, 32'd0, 32'hFFFF_FFFF, 32'd0, 7'd0, CHK_MODEL, NO_MOVE},
		'{ROW_PERIOD, 32'd0, 32'd0, 32'd0, 7'd1, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd100, 32'd100, 32'd1000, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd1100, 32'd2000, 32'd1000, 7'd0, CHK_TYPED,
			'{PCT_FULL, PCT_FULL, 23'd0}},
		'{ROW_BAR, 32'd500, 32'd1000, 32'd950, 7'd0, CHK_TYPED, NO_MOVE},
		'{ROW_BAR, 32'd500, 32'd940, 32'd950, 7'd0, CHK_TYPED,
			'{PCT_FULL, 23'd0, PCT_FULL}},
		'{ROW_BAR, 32'd600, 32'd840, 32'd700, 7'd0, CHK_TYPED, NO_MOVE},
		'{ROW_PERIOD, 32'd0, 32'd0, 32'd0, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd12345, 32'd6789, 32'd10000, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_PERIOD, 32'd0, 32'd0, 32'd0, 7'd127, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd5000, 32'd4000, 32'd4500, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'd5600, 32'd4400, 32'd5500, 7'd0, CHK_MODEL, NO_MOVE},
		'{ROW_BAR, 32'd5200, 32'd3900, 32'd4000, 7'd0, CHK_MODEL, NO_MOVE},
		'{ROW_PERIOD, 32'd0, 32'd0, 32'd0, 7'd64, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, CHK_NONE, NO_MOVE},
		'{ROW_BAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, CHK_TYPED, NO_MOVE},
		'{ROW_BAR, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 7'd0, CHK_MODEL, NO_MOVE},
		'{ROW_BAR, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 7'd0, CHK_MODEL, NO_MOVE}
	};

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_reading(input dmi_reading_t got);
		dmi_reading_t want;
		if (readings_due.size() == 0) begin
			report_mismatch($sformatf("unexpected reading adx=%0d +di=%0d -di=%0d",
				got.adx, got.pdi, got.ndi));
			return;
		end
		want = readings_due[0];
		readings_due.delete(0);
		if (got.adx != want.adx)
			report_mismatch($sformatf("adx got %0d want %0d", got.adx, want.adx));
		if (got.pdi != want.pdi)
			report_mismatch($sformatf("+di got %0d want %0d", got.pdi, want.pdi));
		if (got.ndi != want.ndi)
			report_mismatch($sformatf("-di got %0d want %0d", got.ndi, want.ndi));
	endtask

	// Result side: take transfers, then pick the next ready
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			check_reading('{res_ch.adx_value, res_ch.plus_di, res_ch.minus_di});
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (steady_mode) begin
			res_ch.ready <= 1'b1;
		end else if ($urandom_range(0, 99) < IDLE_PCT) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: too long without any transfer
	always @(posedge clk) begin
		if ((bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		bar_ch.valid         = 1'b0;
		bar_ch.high_price    = '0;
		bar_ch.low_price     = '0;
		bar_ch.close_price   = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.window_period = PERIOD_RESET;
		res_ch.ready         = 1'b0;
		load_period(PERIOD_RESET);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_PERIOD) begin
				settle();
				write_period(plan[i].period);
			end else begin
				send_bar(plan[i].hi, plan[i].lo, plan[i].cl, plan[i].check, plan[i].typed);
			end
		end

		// Random phases; the first one holds the result side off for a while
		run_phase(7'd14, 80, 1'b0, 1'b1);
		run_phase(7'd2, 60, 1'b0, 1'b0);
		run_phase(7'd1, 40, 1'b0, 1'b0);
		run_phase(7'd64, 120, 1'b1, 1'b0);
		run_phase(7'd0, 10, 1'b0, 1'b0);
		run_phase(7'd100, 90, 1'b0, 1'b0);
		run_phase(7'd5, 60, 1'b0, 1'b0);
		run_phase(7'($urandom_range(1, 20)), 50, 1'b0, 1'b0);
		run_phase(7'd127, 40, 1'b0, 1'b0);

		// Drain and finish
		bar_ch.valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
